FILE: src/ttc_pkg.sv
package ttc_pkg;

  // field widths
  localparam int unsigned CharWidth = 8;
  localparam int unsigned PosWidth  = 8;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned OutDataWidth  = 56;

  // character codes
  localparam logic [CharWidth-1:0] CharTab     = 8'd9;
  localparam logic [CharWidth-1:0] CharNewline = 8'd10;
  localparam logic [CharWidth-1:0] CharReturn  = 8'd13;

  // register indexes
  localparam logic [CfgIndexWidth-1:0] RegScreenWidth   = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegScreenHeight  = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegTextAttribute = 2'd2;

  // register reset values
  localparam logic [PosWidth-1:0] ResetWidth     = 8'd80;
  localparam logic [PosWidth-1:0] ResetHeight    = 8'd25;
  localparam logic [7:0]          ResetAttribute = 8'd15;

  // one result item
  typedef struct packed {
    logic                write_valid;
    logic [PosWidth-1:0] write_row;
    logic [PosWidth-1:0] write_column;
    logic [CharWidth-1:0] glyph;
    logic [7:0]          attribute;
    logic                scroll_up;
    logic [PosWidth-1:0] cursor_row;
    logic [PosWidth-1:0] cursor_column;
  } ttc_result_t;

endpackage

FILE: src/ttc_cursor_step.sv
module ttc_cursor_step #(
  parameter int unsigned TAB_STOP = 8
) (
  input  logic [ttc_pkg::CharWidth-1:0] code,
  input  logic [ttc_pkg::PosWidth-1:0]  row,
  input  logic [ttc_pkg::PosWidth-1:0]  column,
  input  logic [ttc_pkg::PosWidth-1:0]  screen_width,
  input  logic [ttc_pkg::PosWidth-1:0]  screen_height,
  input  logic [7:0]                    text_attribute,
  output ttc_pkg::ttc_result_t          result
);

  localparam int unsigned PosW     = ttc_pkg::PosWidth;
  localparam int unsigned TabDepth = 2 ** PosW;

  logic [PosW-1:0] width_eff;
  logic [PosW-1:0] height_eff;
  logic [PosW-1:0] row_c;
  logic [PosW-1:0] col_c;
  logic [PosW:0]   col_inc;
  logic [PosW:0]   row_inc;
  logic [PosW:0]   tab_next;
  logic            line_scroll;
  logic [PosW-1:0] line_row;
  logic [PosW:0]   tab_next_tbl [TabDepth];

  // next tab stop for every column, fixed at elaboration
  for (genvar g = 0; g < TabDepth; g++) begin : g_tab
    assign tab_next_tbl[g] = (PosW+1)'((g / TAB_STOP + 1) * TAB_STOP);
  end

  // a zero size acts as one, cursor clamped into the screen
  assign width_eff  = (screen_width == '0) ? PosW'(1) : screen_width;
  assign height_eff = (screen_height == '0) ? PosW'(1) : screen_height;
  assign row_c      = (row >= height_eff) ? height_eff - PosW'(1) : row;
  assign col_c      = (column >= width_eff) ? width_eff - PosW'(1) : column;

  assign col_inc  = {1'b0, col_c} + (PosW+1)'(1);
  assign row_inc  = {1'b0, row_c} + (PosW+1)'(1);
  assign tab_next = tab_next_tbl[col_c];

  // moving to the next line, scroll when past the bottom row
  assign line_scroll = (row_inc >= {1'b0, height_eff});
  assign line_row    = line_scroll ? height_eff - PosW'(1) : row_inc[PosW-1:0];

  always_comb begin
    result = '0;
    result.cursor_row    = row_c;
    result.cursor_column = col_c;
    case (code)
      ttc_pkg::CharNewline: begin
        result.cursor_row    = line_row;
        result.cursor_column = '0;
        result.scroll_up     = line_scroll;
      end
      ttc_pkg::CharReturn: begin
        result.cursor_column = '0;
      end
      ttc_pkg::CharTab: begin
        if (tab_next >= {1'b0, width_eff}) begin
          result.cursor_row    = line_row;
          result.cursor_column = '0;
          result.scroll_up     = line_scroll;
        end else begin
          result.cursor_column = tab_next[PosW-1:0];
        end
      end
      default: begin
        result.write_valid  = 1'b1;
        result.write_row    = row_c;
        result.write_column = col_c;
        result.glyph        = code;
        result.attribute    = text_attribute;
        if (col_inc >= {1'b0, width_eff}) begin
          result.cursor_row    = line_row;
          result.cursor_column = '0;
          result.scroll_up     = line_scroll;
        end else begin
          result.cursor_column = col_inc[PosW-1:0];
        end
      end
    endcase
  end

endmodule

FILE: src/text_terminal_cursor_engine_unit.sv
// Text terminal cursor engine.
// Input stream (s_*): one character byte per item. Output stream (m_*): one
// result item per input item, carrying the glyph write (if any), the scroll
// request and the cursor position after the character.
// Configuration: cfg_wr_en with cfg_index 0 = screen width, 1 = screen height,
// 2 = text attribute; the user must write them only while no item is in flight,
// which the block does not enforce. Throughput: one item per cycle while the
// receiver does not stall. The character is held in an input register and the
// cursor update is one pass of combinational logic into the result register;
// the cursor state is updated when the result register is loaded, ready for the next item.
// When the receiver stalls, the result register holds and one more item waits
// in the input register; s_tready drops only when both are full.
// Reset (rst, synchronous): both registers empty, cursor at row 0 column 0,
// width 80, height 25, attribute 15.
module text_terminal_cursor_engine_unit #(
  parameter int unsigned TAB_STOP = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] write_valid, [8:1] write_row, [16:9] write_column, [24:17] glyph,
  // [32:25] attribute, [33] scroll_up, [41:34] cursor_row,
  // [49:42] cursor_column, [55:50] zero
  output logic [ttc_pkg::OutDataWidth-1:0] m_tdata,
  input  logic        cfg_wr_en,
  input  logic [ttc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned PosW = ttc_pkg::PosWidth;

  logic [PosW-1:0] screen_width;
  logic [PosW-1:0] screen_height;
  logic [7:0]      text_attribute;
  logic [PosW-1:0] row_position;
  logic [PosW-1:0] column_position;

  logic                             in_valid;
  logic [ttc_pkg::CharWidth-1:0]    in_code;
  logic                             out_valid;
  ttc_pkg::ttc_result_t             out_result;
  ttc_pkg::ttc_result_t             step_result;
  logic                             advance;

  // input register moves on when the result register is free or being taken
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width   <= ttc_pkg::ResetWidth;
      screen_height  <= ttc_pkg::ResetHeight;
      text_attribute <= ttc_pkg::ResetAttribute;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ttc_pkg::RegScreenWidth:   screen_width   <= cfg_data;
        ttc_pkg::RegScreenHeight:  screen_height  <= cfg_data;
        ttc_pkg::RegTextAttribute: text_attribute <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_code <= s_tdata;
    end
  end

  // cursor update
  ttc_cursor_step #(
    .TAB_STOP(TAB_STOP)
  ) u_step (
    .code           (in_code),
    .row            (row_position),
    .column         (column_position),
    .screen_width   (screen_width),
    .screen_height  (screen_height),
    .text_attribute (text_attribute),
    .result         (step_result)
  );

  // cursor state and result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      row_position    <= '0;
      column_position <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (advance) begin
        row_position    <= step_result.cursor_row;
        column_position <= step_result.cursor_column;
        out_valid       <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {
    (ttc_pkg::OutDataWidth - 50)'(0),
    out_result.cursor_column,
    out_result.cursor_row,
    out_result.scroll_up,
    out_result.attribute,
    out_result.glyph,
    out_result.write_column,
    out_result.write_row,
    out_result.write_valid
  };

`ifndef NO_ASSERTIONS
  // a stalled input means both registers hold an item
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid))
    else $error("input stalled while a register is free");

  // a scroll request always leaves the cursor at column zero
  a_scroll_column: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.scroll_up) |-> (out_result.cursor_column == '0))
    else $error("scroll request with cursor off column zero");

  // control bytes never produce a write, and writes carry no control byte
  a_write_glyph: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.write_valid) |->
      (out_result.glyph != ttc_pkg::CharNewline &&
       out_result.glyph != ttc_pkg::CharReturn &&
       out_result.glyph != ttc_pkg::CharTab))
    else $error("control byte written as a glyph");

  // an item taken into the result register becomes visible next cycle
  a_advance_valid: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after advance");
`endif

endmodule

FILE: test/text_terminal_cursor_engine_unit_tb.sv
`timescale 1ns / 100ps

module text_terminal_cursor_engine_unit_tb;

  localparam int unsigned PosW = ttc_pkg::PosWidth;
  localparam int TabStop     = 8;
  localparam int DrainCycles = 4;
  localparam int StallLimit  = 1000;
  localparam int IdlePct     = 19;

  // cursor and screen predictor, with the queue of results still owed by the block
  class cursor_predictor;
    logic [PosW-1:0]      width_reg;
    logic [PosW-1:0]      height_reg;
    logic [7:0]           attr_reg;
    logic [PosW-1:0]      row;
    logic [PosW-1:0]      col;
    ttc_pkg::ttc_result_t pending_results[$];
    int unsigned          mismatch_count;

    function new();
      width_reg      = ttc_pkg::ResetWidth;
      height_reg     = ttc_pkg::ResetHeight;
      attr_reg       = ttc_pkg::ResetAttribute;
      row            = '0;
      col            = '0;
      mismatch_count = 0;
    endfunction

    function void set_screen(logic [7:0] w, logic [7:0] h, logic [7:0] a);
      width_reg  = w;
      height_reg = h;
      attr_reg   = a;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // column zero of the next row, scroll when it runs off the bottom
    function logic line_feed(int hgt);
      int next_row;
      next_row = int'(row) + 1;
      col = '0;
      if (next_row >= hgt) begin
        row = PosW'(hgt - 1);
        return 1'b1;
      end
      row = PosW'(next_row);
      return 1'b0;
    endfunction

    // work out the result item caused by one accepted character
    function void take_char(logic [ttc_pkg::CharWidth-1:0] code);
      ttc_pkg::ttc_result_t want;
      int          wid;
      int          hgt;
      int          next_col;
      want = '0;
      wid  = (width_reg == 0) ? 1 : int'(width_reg);
      hgt  = (height_reg == 0) ? 1 : int'(height_reg);
      // cursor left outside a shrunken screen is pulled back in
      if (int'(row) >= hgt) row = PosW'(hgt - 1);
      if (int'(col) >= wid) col = PosW'(wid - 1);
      if (code == ttc_pkg::CharNewline) begin
        want.scroll_up = line_feed(hgt);
      end else if (code == ttc_pkg::CharReturn) begin
        col = '0;
      end else if (code == ttc_pkg::CharTab) begin
        next_col = (int'(col) / TabStop + 1) * TabStop;
        if (next_col >= wid) want.scroll_up = line_feed(hgt);
        else col = PosW'(next_col);
      end else begin
        want.write_valid  = 1'b1;
        want.write_row    = row;
        want.write_column = col;
        want.glyph        = code;
        want.attribute    = attr_reg;
        next_col = int'(col) + 1;
        if (next_col >= wid) want.scroll_up = line_feed(hgt);
        else col = PosW'(next_col);
      end
      want.cursor_row    = row;
      want.cursor_column = col;
      pending_results.push_back(want);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: %s wrong, expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    // compare one result item with the oldest one owed
    function void match_result(logic [ttc_pkg::OutDataWidth-1:0] d);
      ttc_pkg::ttc_result_t want;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result item with none owed, data %h", $time, d);
        return;
      end
      want = pending_results.pop_front();
      compare_field("write_valid",   want.write_valid,   d[0]);
      compare_field("write_row",     want.write_row,     d[8:1]);
      compare_field("write_column",  want.write_column,  d[16:9]);
      compare_field("glyph",         want.glyph,         d[24:17]);
      compare_field("attribute",     want.attribute,     d[32:25]);
      compare_field("scroll_up",     want.scroll_up,     d[33]);
      compare_field("cursor_row",    want.cursor_row,    d[41:34]);
      compare_field("cursor_column", want.cursor_column, d[49:42]);
    endfunction
  endclass

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  s_tvalid = 1'b0;
  logic                                  s_tready;
  logic [7:0]                            s_tdata = '0;
  logic                                  m_tvalid;
  logic                                  m_tready = 1'b0;
  logic [ttc_pkg::OutDataWidth-1:0]      m_tdata;
  logic                                  cfg_wr_en = 1'b0;
  logic [ttc_pkg::CfgIndexWidth-1:0]     cfg_index = '0;
  logic [7:0]                            cfg_data = '0;

  cursor_predictor tracker;
  logic            steady = 1'b0;
  int unsigned     quiet_cycles = 0;

  // opening text on the reset screen
  logic [7:0] first_chars[8] = '{8'h41, 8'h00, 8'hFF, ttc_pkg::CharTab, ttc_pkg::CharReturn,
                                 ttc_pkg::CharNewline, 8'h55, 8'hAA};
  // wraps, tabs past the width and scrolls on a 10 by 2 screen
  logic [7:0] wrap_chars[9] = '{8'h78, ttc_pkg::CharTab, ttc_pkg::CharTab,
                                ttc_pkg::CharNewline, ttc_pkg::CharTab, ttc_pkg::CharTab,
                                ttc_pkg::CharTab, 8'h79, 8'h7A};

  text_terminal_cursor_engine_unit #(
    .TAB_STOP(TabStop)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls at random except in a steady stretch
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  // item monitors on both streams
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) tracker.match_result(m_tdata);
      if (s_tvalid && s_tready) tracker.take_char(s_tdata);
    end
  end

  // watchdog on cycles with no item or register write
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one character; valid stays high afterwards unless a gap follows
  task automatic send_char(input logic [7:0] code);
    if (!steady && $urandom_range(0, 99) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < IdlePct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending and wait until every owed result has come
  task automatic drain_text();
    s_tvalid <= 1'b0;
    // let the monitor note the last accepted item first
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_screen(input logic [7:0] w, input logic [7:0] h, input logic [7:0] a);
    cfg_wr_en <= 1'b1;
    cfg_index <= ttc_pkg::RegScreenWidth;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= ttc_pkg::RegScreenHeight;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= ttc_pkg::RegTextAttribute;
    cfg_data  <= a;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_screen(w, h, a);
  endtask

  // random text, newline share set per run, some returns and tabs
  function automatic logic [7:0] pick_char(int nl_pct);
    int r;
    if ($urandom_range(0, 99) < nl_pct) return ttc_pkg::CharNewline;
    r = $urandom_range(0, 99);
    if (r < 8) return ttc_pkg::CharReturn;
    if (r < 16) return ttc_pkg::CharTab;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_text(input int count, input int nl_pct);
    repeat (count) send_char(pick_char(nl_pct));
  endtask

  initial begin
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed text
    foreach (first_chars[i]) send_char(first_chars[i]);
    drain_text();
    load_screen(8'd10, 8'd2, 8'hA5);
    foreach (wrap_chars[i]) send_char(wrap_chars[i]);
    drain_text();

    // random text over a range of screens
    load_screen(8'd1, 8'd1, 8'h00);
    send_text(120, 10);
    drain_text();
    load_screen(8'd255, 8'd255, 8'hFF);
    steady = 1'b1;
    send_text(300, 90);
    drain_text();
    steady = 1'b0;
    load_screen(8'd255, 8'd255, 8'h3C);
    send_text(300, 2);
    drain_text();
    load_screen(8'd0, 8'd0, 8'($urandom_range(0, 255)));
    send_text(100, 10);
    drain_text();
    load_screen(8'd8, 8'd4, 8'($urandom_range(0, 255)));
    send_text(120, 10);
    drain_text();
    load_screen(8'd9, 8'd3, 8'($urandom_range(0, 255)));
    send_text(120, 10);
    drain_text();
    repeat (4) begin
      load_screen(8'($urandom_range(1, 40)), 8'($urandom_range(1, 12)),
                  8'($urandom_range(0, 255)));
      send_text(150, $urandom_range(0, 30));
      drain_text();
    end

    repeat (10) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: text_terminal_cursor_engine_unit.f
src/ttc_pkg.sv
src/ttc_cursor_step.sv
src/text_terminal_cursor_engine_unit.sv
test/text_terminal_cursor_engine_unit_tb.sv
